>>> rtl/dollar_framed_qn_ql_parser_core_macros.svh
// Assertion helpers shared by the parser RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef DOLLAR_FRAMED_QN_QL_PARSER_CORE_MACROS_SVH
`define DOLLAR_FRAMED_QN_QL_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted
`define DFQP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define DFQP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DFQP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define DFQP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

>>> rtl/dfqp_pkg.sv
package dfqp_pkg;

    // ASCII codes recognised by the parser
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_Q      = 8'h51;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_L      = 8'h4C;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Decimal exponents up to six fit in three bits
    localparam int EXP_BITS   = 3;
    localparam int WEIGHT_BITS = 20;
    localparam int TERM_BITS  = 24;

    localparam int OUT_BITS   = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_Q1,
        PH_N,
        PH_QN_NUM,
        PH_L,
        PH_QL_NUM,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        OP_INT,
        OP_FRAC,
        OP_EMIT
    } op_kind_t;

    typedef enum logic {
        SEL_QN,
        SEL_QL
    } acc_sel_t;

    typedef struct packed {
        op_kind_t              kind;
        acc_sel_t              sel;
        logic [3:0]            digit;
        logic [EXP_BITS-1:0]   scale_exp;
    } work_t;

    function automatic logic [WEIGHT_BITS-1:0] pow10(input logic [EXP_BITS-1:0] e);
        logic [WEIGHT_BITS-1:0] w;
        case (e)
            3'd0:    w = 20'd1;
            3'd1:    w = 20'd10;
            3'd2:    w = 20'd100;
            3'd3:    w = 20'd1000;
            3'd4:    w = 20'd10000;
            3'd5:    w = 20'd100000;
            3'd6:    w = 20'd1000000;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/dollar_framed_qn_ql_parser_core.sv
// A closing '$' passes through the work queue; its pop loads the word and raises out_valid.
// Throughput: one byte per cycle; in_stall rises only when the four-word work queue fills,
// which happens only while out_stall holds back a finished word.
// Reset (rst_n low, asynchronous): parser waits for the opening '$', both accumulators
// clear, the work queue empties and out_valid drops. No clearing pass is needed.
module dollar_framed_qn_ql_parser_core
    import dfqp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3,
    parameter int VALUE_BITS  = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_BITS-1:0] quantity_milli,
    output logic [OUT_BITS-1:0] quality_milli
);

    // Front: track the frame grammar ($, Q, N, number, Q, L, number) and the
    // dot / fraction-digit state of the number in progress. Every byte is
    // taken at once unless the queue is full; only bytes that change a value
    // or close a frame turn into a work word. Each number is kept pre-scaled
    // to FRAC_DIGITS decimal places (thousandths by default), so a digit
    // carries the decimal exponent of its place and nothing has to be rescaled when the number ends.
    logic  push;
    work_t push_word;
    logic  queue_full;

    // Back: pop work words, run the saturating multiply-by-ten accumulate
    // or the weighted fraction add, and on a closing '$' move both values
    // into the output register and clear the accumulators.
    logic  pop;
    work_t pop_word;
    logic  has_work;

    dfqp_front #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_word  (push_word)
    );

    // Short queue: lets the front keep taking bytes while a finished word
    // waits on out_stall.
    dfqp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .pop_word  (pop_word),
        .not_empty (has_work)
    );

    dfqp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .has_work       (has_work),
        .work           (pop_word),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quantity_milli (quantity_milli),
        .quality_milli  (quality_milli)
    );

endmodule

>>> rtl/dfqp_front.sv
module dfqp_front
    import dfqp_pkg::*;
#(
    parameter int FRAC_DIGITS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       queue_full,
    output logic       push,
    output work_t      push_word
);

    localparam int FCW = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
    localparam logic [FCW-1:0] FRAC_LIMIT = FCW'(FRAC_DIGITS);
    localparam logic [FCW-1:0] FRAC_ONE   = FCW'(1);

    phase_t         parse_phase_reg, parse_phase_next;
    logic           dot_seen_reg, dot_seen_next;
    logic           number_closed_reg, number_closed_next;
    logic [FCW-1:0] fraction_digits_reg, fraction_digits_next;

    logic accept;
    logic is_dollar, is_dot, is_digit, is_num;
    logic take_int, take_frac, in_number;

    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;

    assign is_dollar = (rx_byte == CHAR_DOLLAR);
    assign is_dot    = (rx_byte == CHAR_DOT);
    assign is_digit  = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign is_num    = is_digit || is_dot;
    assign in_number = (parse_phase_reg == PH_QN_NUM) || (parse_phase_reg == PH_QL_NUM);

    assign take_int  = !dot_seen_reg && !number_closed_reg;
    assign take_frac = dot_seen_reg && !number_closed_reg && (fraction_digits_reg < FRAC_LIMIT);

    // next state
    always_comb
    begin
        parse_phase_next     = parse_phase_reg;
        dot_seen_next        = dot_seen_reg;
        number_closed_next   = number_closed_reg;
        fraction_digits_next = fraction_digits_reg;
        if (accept)
        begin
            if (is_dollar)
            begin
                parse_phase_next     = PH_Q1;
                dot_seen_next        = 1'b0;
                number_closed_next   = 1'b0;
                fraction_digits_next = '0;
            end
            else
            begin
                case (parse_phase_reg)
                    PH_IDLE:
                    begin
                        parse_phase_next = PH_IDLE;
                    end
                    PH_Q1:
                    begin
                        parse_phase_next = (rx_byte == CHAR_Q) ? PH_N : PH_SKIP;
                    end
                    PH_N, PH_L:
                    begin
                        dot_seen_next        = 1'b0;
                        number_closed_next   = 1'b0;
                        fraction_digits_next = '0;
                        if (parse_phase_reg == PH_N)
                        begin
                            parse_phase_next = (rx_byte == CHAR_N) ? PH_QN_NUM : PH_SKIP;
                        end
                        else
                        begin
                            parse_phase_next = (rx_byte == CHAR_L) ? PH_QL_NUM : PH_SKIP;
                        end
                    end
                    PH_QN_NUM, PH_QL_NUM:
                    begin
                        if (is_num)
                        begin
                            if (is_dot)
                            begin
                                if (dot_seen_reg)
                                begin
                                    number_closed_next = 1'b1;
                                end
                                else
                                begin
                                    dot_seen_next = 1'b1;
                                end
                            end
                            else if (take_frac)
                            begin
                                fraction_digits_next = fraction_digits_reg + FRAC_ONE;
                            end
                        end
                        else
                        begin
                            dot_seen_next        = 1'b0;
                            number_closed_next   = 1'b0;
                            fraction_digits_next = '0;
                            if (parse_phase_reg == PH_QN_NUM && rx_byte == CHAR_Q)
                            begin
                                parse_phase_next = PH_L;
                            end
                            else
                            begin
                                parse_phase_next = PH_SKIP;
                            end
                        end
                    end
                    default:
                    begin
                        parse_phase_next = PH_SKIP;
                    end
                endcase
            end
        end
    end

    // outputs: one work word per effective digit or per closing delimiter
    always_comb
    begin
        push                = 1'b0;
        push_word.kind      = OP_EMIT;
        push_word.sel       = (parse_phase_reg == PH_QL_NUM) ? SEL_QL : SEL_QN;
        push_word.digit     = rx_byte[3:0];
        push_word.scale_exp = EXP_BITS'(FRAC_DIGITS);
        if (accept)
        begin
            if (is_dollar)
            begin
                push = (parse_phase_reg != PH_IDLE);
            end
            else if (in_number && is_digit)
            begin
                if (take_int)
                begin
                    push           = 1'b1;
                    push_word.kind = OP_INT;
                end
                else if (take_frac)
                begin
                    push                = 1'b1;
                    push_word.kind      = OP_FRAC;
                    push_word.scale_exp = EXP_BITS'(FRAC_DIGITS - 1)
                                          - EXP_BITS'(fraction_digits_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg     <= PH_IDLE;
            dot_seen_reg        <= 1'b0;
            number_closed_reg   <= 1'b0;
            fraction_digits_reg <= '0;
        end
        else
        begin
            parse_phase_reg     <= parse_phase_next;
            dot_seen_reg        <= dot_seen_next;
            number_closed_reg   <= number_closed_next;
            fraction_digits_reg <= fraction_digits_next;
        end
    end

endmodule

>>> rtl/dfqp_queue.sv
`include "dollar_framed_qn_ql_parser_core_macros.svh"

module dfqp_queue
    import dfqp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_word,
    output logic  full,
    input  logic  pop,
    output work_t pop_word,
    output logic  not_empty
);

    localparam logic [QCNT_BITS-1:0] DEPTH_CNT = QCNT_BITS'(QUEUE_DEPTH);
    localparam logic [QCNT_BITS-1:0] CNT_ONE   = QCNT_BITS'(1);
    localparam logic [QPTR_BITS-1:0] PTR_ONE   = QPTR_BITS'(1);

    work_t                entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == DEPTH_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_word  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `DFQP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT,
                     "queue count beyond depth")
    `DFQP_ASSERT_IMP(a_no_push_full, clk, rst_n, full, !push, "push into full queue")
    `DFQP_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, not_empty, "pop from empty queue")
    `DFQP_ASSERT_NXT(a_count_step, clk, rst_n, push && !pop,
                     count_reg == $past(count_reg) + CNT_ONE,
                     "queue count did not advance on push")

endmodule

>>> rtl/dfqp_back.sv
module dfqp_back
    import dfqp_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                has_work,
    input  work_t               work,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_BITS-1:0] quantity_milli,
    output logic [OUT_BITS-1:0] quality_milli
);

    localparam int SUM_BITS = ((VALUE_BITS + 4 > TERM_BITS) ? VALUE_BITS + 4 : TERM_BITS) + 1;
    localparam logic [VALUE_BITS-1:0] SAT_MAX  = '1;
    localparam logic [SUM_BITS-1:0]   SAT_WIDE = SUM_BITS'(SAT_MAX);

    logic [VALUE_BITS-1:0] quantity_acc_reg, quantity_acc_next;
    logic [VALUE_BITS-1:0] quality_acc_reg, quality_acc_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   quantity_milli_reg, quality_milli_reg;

    logic                  out_free, is_emit;
    logic [VALUE_BITS-1:0] acc_in, acc_sat;
    logic [TERM_BITS-1:0]  term;
    logic [SUM_BITS-1:0]   acc_wide, base, sum;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_emit  = (work.kind == OP_EMIT);
    assign pop      = has_work && (!is_emit || out_free);

    // digit weighted by its decimal place, then a saturating accumulate
    assign acc_in   = (work.sel == SEL_QL) ? quality_acc_reg : quantity_acc_reg;
    assign term     = TERM_BITS'(work.digit) * TERM_BITS'(pow10(work.scale_exp));
    assign acc_wide = SUM_BITS'(acc_in);
    assign base     = (work.kind == OP_INT) ? (acc_wide << 3) + (acc_wide << 1) : acc_wide;
    assign sum      = base + SUM_BITS'(term);
    assign acc_sat  = (sum > SAT_WIDE) ? SAT_MAX : sum[VALUE_BITS-1:0];

    always_comb
    begin
        quantity_acc_next = quantity_acc_reg;
        quality_acc_next  = quality_acc_reg;
        out_valid_next    = out_valid_reg && out_stall;
        if (pop)
        begin
            if (is_emit)
            begin
                quantity_acc_next = '0;
                quality_acc_next  = '0;
                out_valid_next    = 1'b1;
            end
            else if (work.sel == SEL_QL)
            begin
                quality_acc_next = acc_sat;
            end
            else
            begin
                quantity_acc_next = acc_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_emit)
        begin
            quantity_milli_reg <= OUT_BITS'(quantity_acc_reg);
            quality_milli_reg  <= OUT_BITS'(quality_acc_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantity_acc_reg <= '0;
            quality_acc_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            quantity_acc_reg <= quantity_acc_next;
            quality_acc_reg  <= quality_acc_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quantity_milli = quantity_milli_reg;
    assign quality_milli  = quality_milli_reg;

endmodule
